// File: src/cache_hit_miss_tracker_defines.svh
// ----------------------------------------------------------------------------
// cache_hit_miss_tracker_defines
// assertion macros used by the tracker top level
// ----------------------------------------------------------------------------
`ifndef CACHE_HIT_MISS_TRACKER_DEFINES_SVH
`define CACHE_HIT_MISS_TRACKER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define CHMT_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while in reset
`define CHMT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/chmt_pkg.sv
// ----------------------------------------------------------------------------
// chmt_pkg
// shared widths, opcodes and controller/datapath interface types
// ----------------------------------------------------------------------------
package chmt_pkg;

  localparam int ENTRIES_DEFAULT = 16;
  localparam int OP_W     = 2;
  localparam int ADDR_W   = 32;
  localparam int IN_IDX_W = 8;
  localparam int CFG_W    = 11;
  localparam int CNT_W    = 32;
  localparam int STEP_W   = 5;

  localparam logic [CFG_W-1:0]  WPB_RESET = 11'd4;
  localparam logic [STEP_W-1:0] DIV_LAST  = 5'd31;
  localparam logic [CNT_W-1:0]  CNT_SAT   = 32'hFFFF_FFFF;

  localparam logic [OP_W-1:0] OP_ACCESS = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic scan_rd;
    logic commit;
  } chmt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_last;
    logic scan_last;
  } chmt_status_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_SAT) ? v : v + 1'b1;
  endfunction

endpackage

// File: src/chmt_ctrl.sv
// ----------------------------------------------------------------------------
// chmt_ctrl
// sequencer: divide, scan, drain, commit; other opcodes go straight to commit
// ----------------------------------------------------------------------------
module chmt_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [chmt_pkg::OP_W-1:0] opcode,
  input  chmt_pkg::chmt_status_t    status,
  output chmt_pkg::chmt_cmd_t       cmd,
  output logic                      busy
);
  import chmt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIVIDE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            busy  <= 1'b1;
            state <= (opcode == OP_ACCESS) ? S_DIVIDE : S_COMMIT;
          end
        end
        S_DIVIDE: begin
          if (status.div_last) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (status.scan_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_COMMIT;
        end
        S_COMMIT: begin
          busy  <= 1'b0;
          state <= S_IDLE;
        end
        default: begin
          busy  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.load     = (state == S_IDLE) && start;
    cmd.div_step = (state == S_DIVIDE);
    cmd.scan_rd  = (state == S_SCAN);
    cmd.commit   = (state == S_COMMIT);
  end

endmodule

// File: src/chmt_datapath.sv
// ----------------------------------------------------------------------------
// chmt_datapath
// bit-serial divider, tag store scan, valid bits and counters
// ----------------------------------------------------------------------------
module chmt_datapath #(
  parameter int ENTRIES = chmt_pkg::ENTRIES_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [chmt_pkg::CFG_W-1:0]    cfg_data,
  input  logic [chmt_pkg::OP_W-1:0]     opcode,
  input  logic [chmt_pkg::ADDR_W-1:0]   address,
  input  logic [chmt_pkg::IN_IDX_W-1:0] entry_index,
  input  chmt_pkg::chmt_cmd_t           cmd,
  output chmt_pkg::chmt_status_t        status,
  output logic                          done,
  output logic                          was_hit,
  output logic                          was_miss,
  output logic                          bad_index,
  output logic [chmt_pkg::CNT_W-1:0]    hits_total,
  output logic [chmt_pkg::CNT_W-1:0]    misses_total,
  output logic [chmt_pkg::CNT_W-1:0]    items_total
);
  import chmt_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [IDX_W:0]    N_EXT    = (IDX_W + 1)'(ENTRIES);
  localparam logic [IN_IDX_W:0] N_IN     = (IN_IDX_W + 1)'(ENTRIES);

  logic [CFG_W-1:0]    words_per_block;
  logic [OP_W-1:0]     op_q;
  logic [IN_IDX_W-1:0] index_q;
  logic [CFG_W-1:0]    divisor;
  logic [ADDR_W-1:0]   quot;
  logic [CFG_W-1:0]    rem;
  logic [IDX_W-1:0]    slot;
  logic [STEP_W-1:0]   step;
  logic [IDX_W-1:0]    scan_idx;
  logic [IDX_W-1:0]    rd_idx;
  logic                rd_vld;
  logic [ADDR_W-1:0]   rd_data;
  logic                hit_flag;
  logic [ENTRIES-1:0]  valid;
  logic [ADDR_W-1:0]   tag_mem [ENTRIES];
  logic [CNT_W-1:0]    hit_cnt;
  logic [CNT_W-1:0]    miss_cnt;
  logic [CNT_W-1:0]    item_cnt;

  // one restoring step per cycle, slot remainder follows the quotient bits
  logic [CFG_W:0]   trial;
  logic             q_bit;
  logic [CFG_W-1:0] rem_next;
  logic [IDX_W:0]   slot_ext;
  logic [IDX_W-1:0] slot_next;
  logic             match;

  always_comb begin
    trial    = {rem, quot[ADDR_W-1]};
    q_bit    = (trial >= {1'b0, divisor});
    rem_next = q_bit ? CFG_W'(trial - {1'b0, divisor}) : trial[CFG_W-1:0];
    slot_ext = {slot, q_bit};
    slot_next = (slot_ext >= N_EXT) ? IDX_W'(slot_ext - N_EXT) : slot_ext[IDX_W-1:0];
    match    = rd_vld && valid[rd_idx] && (rd_data == quot);
  end

  assign status.div_last  = (step == DIV_LAST);
  assign status.scan_last = (scan_idx == LAST_IDX);

  assign hits_total   = hit_cnt;
  assign misses_total = miss_cnt;
  assign items_total  = item_cnt;

  // item capture, divider and scan
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q     <= opcode;
      index_q  <= entry_index;
      quot     <= address;
      rem      <= '0;
      slot     <= '0;
      divisor  <= (words_per_block == '0) ? CFG_W'(1) : words_per_block;
      step     <= '0;
      scan_idx <= '0;
      hit_flag <= 1'b0;
    end else begin
      if (cmd.div_step) begin
        quot <= {quot[ADDR_W-2:0], q_bit};
        rem  <= rem_next;
        slot <= slot_next;
        step <= step + 1'b1;
      end
      if (cmd.scan_rd && !status.scan_last) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (match) begin
        hit_flag <= 1'b1;
      end
    end
  end

  // tag store: one read port for the scan, one write on a fill
  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      rd_data <= tag_mem[scan_idx];
    end
    if (cmd.commit && (op_q == OP_ACCESS) && !hit_flag) begin
      tag_mem[slot] <= quot;
    end
    rd_idx <= scan_idx;
  end

  // config, valid bits, counters and the done strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      words_per_block <= WPB_RESET;
      valid           <= '0;
      hit_cnt         <= '0;
      miss_cnt        <= '0;
      item_cnt        <= '0;
      rd_vld          <= 1'b0;
      done            <= 1'b0;
    end else begin
      rd_vld <= cmd.scan_rd;
      done   <= cmd.commit;
      if (cfg_write) begin
        words_per_block <= cfg_data;
      end
      if (cmd.commit) begin
        item_cnt <= sat_inc(item_cnt);
        unique case (op_q)
          OP_ACCESS: begin
            if (hit_flag) begin
              hit_cnt <= sat_inc(hit_cnt);
            end else begin
              miss_cnt    <= sat_inc(miss_cnt);
              valid[slot] <= 1'b1;
            end
          end
          OP_DELETE: begin
            if ({1'b0, index_q} < N_IN) begin
              valid[index_q[IDX_W-1:0]] <= 1'b0;
            end
          end
          OP_CLEAR: begin
            valid <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // result flags are payload, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      was_hit   <= (op_q == OP_ACCESS) && hit_flag;
      was_miss  <= (op_q == OP_ACCESS) && !hit_flag;
      bad_index <= (op_q == OP_DELETE) && ({1'b0, index_q} >= N_IN);
    end
  end

endmodule

// File: src/cache_hit_miss_tracker.sv
// ----------------------------------------------------------------------------
// cache_hit_miss_tracker
// block lookup tracker with saturating hit, miss and item counters
// ----------------------------------------------------------------------------
//
// channel   direction  handshake             payload
// item      in         start && !busy        opcode, address, entry_index
// result    out        done (one cycle)      was_hit, was_miss, bad_index,
//                                            hits_total, misses_total, items_total
// config    in         cfg_write             cfg_data (words_per_block)
//
// an access item goes from acceptance to its done strobe through the address
// divider, one bit per cycle, the scan of ENTRIES slots through the single
// read port of the tag store, a drain state to compare the last read and a
// commit state; busy drops with the strobe, so no new item is taken before it
// delete, clear and unused opcodes go from acceptance straight to commit
// synchronous reset clears valid bits, counters and sets words_per_block to 4
// the result is shown for exactly one cycle; the receiver cannot stall it
//
module cache_hit_miss_tracker #(
  parameter int ENTRIES = chmt_pkg::ENTRIES_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [chmt_pkg::OP_W-1:0]     opcode,
  input  logic [chmt_pkg::ADDR_W-1:0]   address,
  input  logic [chmt_pkg::IN_IDX_W-1:0] entry_index,
  input  logic                          cfg_write,
  input  logic [chmt_pkg::CFG_W-1:0]    cfg_data,
  output logic                          done,
  output logic                          was_hit,
  output logic                          was_miss,
  output logic                          bad_index,
  output logic [chmt_pkg::CNT_W-1:0]    hits_total,
  output logic [chmt_pkg::CNT_W-1:0]    misses_total,
  output logic [chmt_pkg::CNT_W-1:0]    items_total
);
  import chmt_pkg::*;

  `include "cache_hit_miss_tracker_defines.svh"

  // command and status between sequencer and datapath
  chmt_cmd_t    cmd;
  chmt_status_t status;

  // result flags gathered for the checks below
  logic [2:0]   flags;

  assign flags = {was_hit, was_miss, bad_index};

  // sequencer: owns busy and walks each item through its phases
  chmt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // datapath: divider, tag store, valid bits, counters and result flags
  chmt_datapath #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .opcode       (opcode),
    .address      (address),
    .entry_index  (entry_index),
    .cmd          (cmd),
    .status       (status),
    .done         (done),
    .was_hit      (was_hit),
    .was_miss     (was_miss),
    .bad_index    (bad_index),
    .hits_total   (hits_total),
    .misses_total (misses_total),
    .items_total  (items_total)
  );

  // the strobe comes only once the sequencer is free again
  `CHMT_ASSERT_SAME(a_done_not_busy, clk, rst, done, !busy, "result strobe while busy")
  // at most one of the three flags per item
  `CHMT_ASSERT_SAME(a_one_flag, clk, rst, done, $onehot0(flags), "more than one result flag set")
  // an accepted item always makes the block busy
  `CHMT_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "item accepted but not busy")
  // every delivered item has been counted
  `CHMT_ASSERT_SAME(a_items_counted, clk, rst, done, items_total != '0, "item counter zero at a result")

endmodule
